### hw/rtl/ibav_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibav_pkg: shared types and constants for the inter-beat interval validator
// Field widths, register reset values, register indexes, state encodings and
// the median reply structure used between the sequencer and the top level.
// ----------------------------------------------------------------------------
package ibav_pkg;

  // Field widths fixed by the interface.
  localparam int TIME_W     = 32;
  localparam int LEVEL_W    = 32;
  localparam int SAMPLE_W   = 32;
  localparam int IVL_W      = 16;
  localparam int BLEVEL_W   = 16;
  localparam int CONF_W     = 7;
  localparam int PCT_W      = 8;
  localparam int THR_W      = 8;
  localparam int PROD_W     = IVL_W + PCT_W;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [IVL_W-1:0] IVL_MIN_RST  = 16'd300;
  localparam logic [IVL_W-1:0] IVL_MAX_RST  = 16'd2000;
  localparam logic [PCT_W-1:0] CHG_PCT_RST  = 8'd30;
  localparam logic [THR_W-1:0] CONF_THR_RST = 8'd50;

  // Confidence levels and scaling.
  localparam logic [CONF_W-1:0]   CONF_FULL  = 7'd100;
  localparam logic [CONF_W-1:0]   CONF_HALF  = 7'd50;
  localparam logic [CONF_W-1:0]   CONF_NONE  = 7'd0;
  localparam logic [PCT_W-1:0]    PCT_SCALE  = 8'd100;
  localparam logic [IVL_W-1:0]    IVL_SAT    = 16'hFFFF;
  localparam logic [BLEVEL_W-1:0] LEVEL_SAT  = 16'hFFFF;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_IVL_MIN  = 2'd0,
    CFG_IVL_MAX  = 2'd1,
    CFG_CHG_PCT  = 2'd2,
    CFG_CONF_THR = 2'd3
  } cfg_idx_t;

  // Median sequencer states.
  typedef enum logic [2:0] {
    MS_IDLE,
    MS_LOAD,
    MS_CAND,
    MS_SCAN,
    MS_CHECK
  } med_state_t;

  // Top-level control states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RANK,
    ST_DECIDE,
    ST_RESULT
  } top_state_t;

  // Reply from the median sequencer.
  typedef struct packed {
    logic             done;
    logic [IVL_W-1:0] median;
  } med_rsp_t;

endpackage

### hw/rtl/ibav_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibav_if: peak and beat channels
// Valid/ready channels carrying one detected peak in and one beat word out.
// ----------------------------------------------------------------------------
interface ibav_in_if import ibav_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [TIME_W-1:0]          peak_time_ms;
  logic signed [LEVEL_W-1:0]  peak_level;
  logic [SAMPLE_W-1:0]        peak_sample;

  modport source (output valid, peak_time_ms, peak_level, peak_sample, input ready);
  modport sink (input valid, peak_time_ms, peak_level, peak_sample, output ready);
endinterface

interface ibav_out_if import ibav_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [TIME_W-1:0]     beat_time_ms;
  logic [IVL_W-1:0]      interval_ms;
  logic [IVL_W-1:0]      previous_interval_ms;
  logic [CONF_W-1:0]     confidence_pct;
  logic                  artifact_flag;
  logic                  low_confidence_flag;
  logic [BLEVEL_W-1:0]   beat_level;
  logic [SAMPLE_W-1:0]   beat_sample;

  modport source (output valid, beat_time_ms, interval_ms, previous_interval_ms,
                  confidence_pct, artifact_flag, low_confidence_flag, beat_level,
                  beat_sample, input ready);
  modport sink (input valid, beat_time_ms, interval_ms, previous_interval_ms,
                confidence_pct, artifact_flag, low_confidence_flag, beat_level,
                beat_sample, output ready);
endinterface

### hw/rtl/ibav_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibav_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ibav_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/ibav_median.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibav_median: ring store and rank-select median sequencer
// Holds the interval ring in a RAM and finds the element of rank count/2 by
// taking each entry in turn as a candidate and counting the entries below it.
// ----------------------------------------------------------------------------
module ibav_median import ibav_pkg::*; #(
  parameter int RING_DEPTH = 10,
  parameter int CNT_W      = $clog2(RING_DEPTH + 1),
  parameter int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] count,
  input  logic             ring_we,
  input  logic [IDX_W-1:0] ring_waddr,
  input  logic [IVL_W-1:0] ring_wdata,
  output med_rsp_t         rsp
);

  med_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] n_r, i_r, j_r, lt_r, le_r;
  logic [IVL_W-1:0] cand_r, median_r;
  logic             done_r;
  logic [CNT_W-1:0] i_inc, half_n;
  logic [CNT_W-1:0] raddr_full;
  logic [IVL_W-1:0] rd_data;
  logic             found, chk_end;

  assign i_inc   = i_r + 1'b1;
  assign half_n  = n_r >> 1;
  assign found   = (lt_r <= half_n) && (half_n < le_r);
  assign chk_end = found || (i_inc == n_r);

  ibav_ram #(
    .WIDTH (IVL_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .raddr (raddr_full[IDX_W-1:0]),
    .rdata (rd_data)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      MS_IDLE: begin
        if (start && (count != '0)) begin
          state_nxt = MS_LOAD;
        end
      end
      MS_LOAD:  state_nxt = MS_CAND;
      MS_CAND:  state_nxt = MS_SCAN;
      MS_SCAN: begin
        if (j_r == n_r) begin
          state_nxt = MS_CHECK;
        end
      end
      MS_CHECK: state_nxt = chk_end ? MS_IDLE : MS_CAND;
      default:  state_nxt = MS_IDLE;
    endcase
  end

  // Read address: candidate loads and scan reads share the one read port.
  always_comb begin
    raddr_full = '0;
    unique case (state_r)
      MS_LOAD:  raddr_full = i_r;
      MS_CAND:  raddr_full = '0;
      MS_SCAN:  raddr_full = (j_r < n_r) ? j_r : '0;
      MS_CHECK: raddr_full = (i_inc < n_r) ? i_inc : '0;
      default:  raddr_full = '0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= ((state_r == MS_IDLE) && start && (count == '0)) ||
                 ((state_r == MS_CHECK) && chk_end);
    end
  end

  // Ranking datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      MS_IDLE: begin
        if (start) begin
          n_r      <= count;
          i_r      <= '0;
          median_r <= '0;
        end
      end
      MS_CAND: begin
        cand_r <= rd_data;
        j_r    <= CNT_W'(1);
        lt_r   <= '0;
        le_r   <= '0;
      end
      MS_SCAN: begin
        lt_r <= lt_r + CNT_W'(rd_data < cand_r);
        le_r <= le_r + CNT_W'(rd_data <= cand_r);
        if (j_r != n_r) begin
          j_r <= j_r + 1'b1;
        end
      end
      MS_CHECK: begin
        if (chk_end) begin
          median_r <= cand_r;
        end else begin
          i_r <= i_inc;
        end
      end
      default: ;
    endcase
  end

  assign rsp.done   = done_r;
  assign rsp.median = median_r;

endmodule

### hw/rtl/ibi_artifact_validator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibi_artifact_validator_core: inter-beat interval plausibility checker
// Turns detected pulse peaks into beat words with interval, confidence and
// artifact flags, checking each interval against a window and a running median.
// ----------------------------------------------------------------------------
//   channel   | direction | handshake        | word
//   in_chan   | in        | valid / ready    | peak time, level, sample
//   out_chan  | out       | valid / ready    | beat time, intervals, flags
//   cfg_*     | in        | cfg_we (no wait) | register index and value
//
// The first peak after reset gives no beat.
// Each later peak is ranked against the ring by a rank-select scan over the ring RAM's read port.
// A finished beat waits in the output register while the next peak is taken.
// Reset is synchronous; the ring RAM is not cleared, only written entries are read.
// ----------------------------------------------------------------------------
module ibi_artifact_validator_core import ibav_pkg::*; #(
  parameter int RING_DEPTH = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ibav_in_if.sink               in_chan,
  ibav_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  // Configuration registers.
  logic [IVL_W-1:0] ivl_min_r, ivl_max_r;
  logic [PCT_W-1:0] chg_pct_r;
  logic [THR_W-1:0] conf_thr_r;

  // Control state.
  top_state_t       state_r, state_nxt;
  logic             seen_r;
  logic [CNT_W-1:0] ring_count_r;
  logic [IDX_W-1:0] wpos_r;
  logic             start_r;
  logic             out_valid_r;

  // Item payload.
  logic [TIME_W-1:0]   last_time_r;
  logic [IVL_W-1:0]    last_ivl_r;
  logic [TIME_W-1:0]   time_r;
  logic [IVL_W-1:0]    ivl_r;
  logic [BLEVEL_W-1:0] level_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [IVL_W-1:0]    med_r;
  logic [IVL_W-1:0]    diff_r;
  logic [PROD_W-1:0]   prod_r;
  logic                rng_fail_r;

  // Output word register.
  logic [TIME_W-1:0]   o_time_r;
  logic [IVL_W-1:0]    o_ivl_r, o_prev_r;
  logic [CONF_W-1:0]   o_conf_r;
  logic                o_art_r, o_low_r;
  logic [BLEVEL_W-1:0] o_level_r;
  logic [SAMPLE_W-1:0] o_sample_r;

  logic                in_acc, out_free, load_out;
  logic [TIME_W-1:0]   dt;
  logic [IVL_W-1:0]    ivl_new;
  logic [BLEVEL_W-1:0] level_new;
  logic [PROD_W-2:0]   diff_scaled;
  logic                cont_fail, art_res, low_res;
  logic [CONF_W-1:0]   conf_res;
  med_rsp_t            med_rsp;

  // Interval since the previous peak: zero when time ran backwards, saturated.
  assign dt = in_chan.peak_time_ms - last_time_r;
  always_comb begin
    if (in_chan.peak_time_ms < last_time_r) begin
      ivl_new = '0;
    end else if (|dt[TIME_W-1:IVL_W]) begin
      ivl_new = IVL_SAT;
    end else begin
      ivl_new = dt[IVL_W-1:0];
    end
  end

  // Amplitude clamp to the unsigned 16-bit range.
  always_comb begin
    if (in_chan.peak_level[LEVEL_W-1]) begin
      level_new = '0;
    end else if (|in_chan.peak_level[LEVEL_W-2:BLEVEL_W]) begin
      level_new = LEVEL_SAT;
    end else begin
      level_new = in_chan.peak_level[BLEVEL_W-1:0];
    end
  end

  // Continuity check: diff > floor(median*pct/100) holds exactly when
  // 100*diff > median*pct, so no divider is needed.
  assign diff_scaled = (PROD_W-1)'(diff_r) * (PROD_W-1)'(PCT_SCALE);
  assign cont_fail   = (med_r != '0) && ({1'b0, diff_scaled} > prod_r);
  assign art_res     = rng_fail_r || cont_fail;
  always_comb begin
    if (rng_fail_r) begin
      conf_res = CONF_NONE;
    end else if (cont_fail) begin
      conf_res = CONF_HALF;
    end else begin
      conf_res = CONF_FULL;
    end
  end
  assign low_res = {1'b0, conf_res} < conf_thr_r;

  // Median sequencer with the ring RAM.
  ibav_median #(
    .RING_DEPTH (RING_DEPTH)
  ) u_median (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start_r),
    .count      (ring_count_r),
    .ring_we    (load_out),
    .ring_waddr (wpos_r),
    .ring_wdata (ivl_r),
    .rsp        (med_rsp)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && seen_r) begin
          state_nxt = ST_RANK;
        end
      end
      ST_RANK: begin
        if (med_rsp.done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State-driven outputs.
  always_comb begin
    in_chan.ready = 1'b0;
    load_out      = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_chan.ready = 1'b1;
      ST_RESULT: load_out      = out_free;
      default: ;
    endcase
  end

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivl_min_r  <= IVL_MIN_RST;
      ivl_max_r  <= IVL_MAX_RST;
      chg_pct_r  <= CHG_PCT_RST;
      conf_thr_r <= CONF_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_IVL_MIN:  ivl_min_r  <= cfg_wdata[IVL_W-1:0];
        CFG_IVL_MAX:  ivl_max_r  <= cfg_wdata[IVL_W-1:0];
        CFG_CHG_PCT:  chg_pct_r  <= cfg_wdata[PCT_W-1:0];
        CFG_CONF_THR: conf_thr_r <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Control registers and beat history.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      seen_r       <= 1'b0;
      last_time_r  <= '0;
      last_ivl_r   <= '0;
      ring_count_r <= '0;
      wpos_r       <= '0;
      start_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_acc && seen_r;
      if (in_acc) begin
        seen_r      <= 1'b1;
        last_time_r <= in_chan.peak_time_ms;
        if (!seen_r) begin
          last_ivl_r <= '0;
        end
      end
      if (load_out) begin
        last_ivl_r <= ivl_r;
        wpos_r     <= (wpos_r == IDX_W'(RING_DEPTH - 1)) ? '0 : wpos_r + 1'b1;
        if (ring_count_r != CNT_W'(RING_DEPTH)) begin
          ring_count_r <= ring_count_r + 1'b1;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item datapath: capture, median, window and continuity terms.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      time_r   <= in_chan.peak_time_ms;
      ivl_r    <= ivl_new;
      level_r  <= level_new;
      sample_r <= in_chan.peak_sample;
    end
    if ((state_r == ST_RANK) && med_rsp.done) begin
      med_r <= med_rsp.median;
    end
    if (state_r == ST_DECIDE) begin
      prod_r     <= PROD_W'(med_r) * PROD_W'(chg_pct_r);
      diff_r     <= (ivl_r >= med_r) ? (ivl_r - med_r) : (med_r - ivl_r);
      rng_fail_r <= (ivl_r < ivl_min_r) || (ivl_r > ivl_max_r);
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      o_time_r   <= time_r;
      o_ivl_r    <= ivl_r;
      o_prev_r   <= last_ivl_r;
      o_conf_r   <= conf_res;
      o_art_r    <= art_res;
      o_low_r    <= low_res;
      o_level_r  <= level_r;
      o_sample_r <= sample_r;
    end
  end

  assign out_chan.valid                = out_valid_r;
  assign out_chan.beat_time_ms         = o_time_r;
  assign out_chan.interval_ms          = o_ivl_r;
  assign out_chan.previous_interval_ms = o_prev_r;
  assign out_chan.confidence_pct       = o_conf_r;
  assign out_chan.artifact_flag        = o_art_r;
  assign out_chan.low_confidence_flag  = o_low_r;
  assign out_chan.beat_level           = o_level_r;
  assign out_chan.beat_sample          = o_sample_r;

`ifndef NO_ASSERTIONS
  // While the ring is filling, the write position tracks the fill count.
  a_wpos_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ring_count_r < CNT_W'(RING_DEPTH)) |-> (CNT_W'(wpos_r) == ring_count_r))
    else $error("ring write position out of step with fill count");

  // The median reply only arrives while a peak is being ranked.
  a_med_done_in_rank: assert property (@(posedge clk) disable iff (!rst_n)
    med_rsp.done |-> (state_r == ST_RANK))
    else $error("median reply outside the ranking phase");

  // A finished beat is held back while the previous word is still waiting.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RESULT) && out_valid_r && !out_chan.ready) |=>
    (state_r == ST_RESULT))
    else $error("beat word overwritten before it was taken");

  // Full confidence exactly when no artifact was found.
  a_conf_matches_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((o_conf_r == CONF_FULL) == !o_art_r) &&
    ((o_conf_r == CONF_FULL) || (o_conf_r == CONF_HALF) || (o_conf_r == CONF_NONE)))
    else $error("confidence and artifact flag disagree");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the inter-beat interval validator
// Drives peak words through the input channel and keeps its own copy of the
// interval window, the median ring and the confidence rules. Each beat word
// that the block returns is checked field by field against that prediction.
// Random gaps are applied on the input channel and back-pressure on the output.
// ----------------------------------------------------------------------------
module tb_top;
  import ibav_pkg::*;

  localparam int RING_DEPTH   = 10;
  localparam int DRAIN_CYCLES = 150;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int PHASE_ITEMS  = 235;

  // One expected beat word, in the field order of the output channel.
  typedef struct packed {
    logic [TIME_W-1:0]   beat_time;
    logic [IVL_W-1:0]    ivl;
    logic [IVL_W-1:0]    prev_ivl;
    logic [CONF_W-1:0]   conf;
    logic                art;
    logic                low;
    logic [BLEVEL_W-1:0] level;
    logic [SAMPLE_W-1:0] sample;
  } beat_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_t              cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ibav_in_if  peak_if ();
  ibav_out_if beat_if ();

  ibi_artifact_validator_core #(
    .RING_DEPTH(RING_DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (peak_if),
    .out_chan (beat_if),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the registers and of the beat tracking state.
  logic [IVL_W-1:0]    win_min;
  logic [IVL_W-1:0]    win_max;
  logic [PCT_W-1:0]    dev_pct;
  logic [THR_W-1:0]    conf_floor;
  bit                  have_first;
  logic [TIME_W-1:0]   prev_time;
  logic [IVL_W-1:0]    prev_ivl;
  logic [IVL_W-1:0]    ivl_hist [RING_DEPTH];
  int                  hist_pos;
  int                  hist_fill;

  beat_t               pending_beats [$];
  int                  error_count    = 0;
  int                  peaks_sent     = 0;
  int                  beats_checked  = 0;
  int                  settings_used  = 0;
  int unsigned         cycle_count    = 0;
  int                  stall_left     = 0;
  bit                  gaps_on        = 1'b1;
  bit                  stalls_on      = 1'b1;
  logic [TIME_W-1:0]   now_ms;
  logic [SAMPLE_W-1:0] sample_no;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Upper middle of the interval history, ranked ascending; zero when empty.
  function automatic logic [IVL_W-1:0] hist_median();
    logic [IVL_W-1:0] ranked [RING_DEPTH];
    logic [IVL_W-1:0] key;
    int               j;
    if (hist_fill == 0) return '0;
    for (int i = 0; i < hist_fill; i++) ranked[i] = ivl_hist[i];
    for (int i = 1; i < hist_fill; i++) begin
      key = ranked[i];
      j = i;
      while (j > 0 && ranked[j-1] > key) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = key;
    end
    return ranked[hist_fill / 2];
  endfunction

  // Works out the beat word that an accepted peak word should give, if any.
  function automatic void track_peak(logic [TIME_W-1:0] t, logic [LEVEL_W-1:0] lvl,
                                     logic [SAMPLE_W-1:0] smp);
    beat_t       b;
    logic [31:0] dt;
    logic [31:0] med;
    logic [31:0] diff;
    logic [31:0] lim;
    // The very first peak only sets the time base.
    if (!have_first) begin
      have_first = 1'b1;
      prev_time  = t;
      prev_ivl   = '0;
      return;
    end
    dt    = (t >= prev_time) ? t - prev_time : 32'd0;
    b.ivl = (dt > 32'h0000_FFFF) ? IVL_SAT : dt[IVL_W-1:0];

    // Plausibility window.
    b.conf = CONF_FULL;
    b.art  = 1'b0;
    if (b.ivl < win_min || b.ivl > win_max) begin
      b.art  = 1'b1;
      b.conf = CONF_NONE;
    end

    // Continuity against the running median; skipped when the median is zero.
    med = hist_median();
    if (med != 0) begin
      diff = (b.ivl >= med) ? b.ivl - med : med - b.ivl;
      lim  = (med * dev_pct) / PCT_SCALE;
      if (diff > lim) begin
        b.art  = 1'b1;
        b.conf = (b.conf >= CONF_HALF) ? b.conf - CONF_HALF : CONF_NONE;
      end
    end
    b.low = (b.conf < conf_floor);

    // The raw interval always enters the history.
    ivl_hist[hist_pos] = b.ivl;
    hist_pos = (hist_pos == RING_DEPTH - 1) ? 0 : hist_pos + 1;
    if (hist_fill < RING_DEPTH) hist_fill++;

    b.level     = lvl[LEVEL_W-1] ? '0 :
                  (lvl > 32'h0000_FFFF) ? LEVEL_SAT : lvl[BLEVEL_W-1:0];
    b.beat_time = t;
    b.prev_ivl  = prev_ivl;
    b.sample    = smp;
    pending_beats.push_back(b);
    prev_time = t;
    prev_ivl  = b.ivl;
  endfunction

  // Offers one peak word, with an occasional gap first, and waits for it to be taken.
  // Valid is left high so that a following word goes out back to back.
  task automatic send_peak(input logic [TIME_W-1:0] t, input logic [LEVEL_W-1:0] lvl,
                           input logic [SAMPLE_W-1:0] smp);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      peak_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    peak_if.valid        <= 1'b1;
    peak_if.peak_time_ms <= t;
    peak_if.peak_level   <= lvl;
    peak_if.peak_sample  <= smp;
    @(posedge clk);
    while (!peak_if.ready) @(posedge clk);
    track_peak(t, lvl, smp);
    peaks_sent++;
  endtask

  // Advances the time base by a signed gap and sends a peak there.
  task automatic send_after(input int gap_ms, input logic [LEVEL_W-1:0] lvl);
    now_ms = now_ms + gap_ms;
    send_peak(now_ms, lvl, sample_no);
    sample_no = sample_no + 97;
  endtask

  // Holds the sender until every beat word has come back, then lets the
  // block finish any peak that gives no beat.
  task automatic wait_idle();
    peak_if.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Writes all four registers while the block is idle. The byte-wide ones get
  // rubbish in the upper byte, which the block must drop.
  task automatic apply_config(input logic [IVL_W-1:0] lo, input logic [IVL_W-1:0] hi,
                              input logic [PCT_W-1:0] pct, input logic [THR_W-1:0] thr);
    logic [7:0] junk;
    wait_idle();
    junk = 8'($urandom);
    put_reg(CFG_IVL_MIN, lo);
    put_reg(CFG_IVL_MAX, hi);
    put_reg(CFG_CHG_PCT, {junk, pct});
    junk = 8'($urandom);
    put_reg(CFG_CONF_THR, {junk, thr});
    cfg_we     <= 1'b0;
    win_min    = lo;
    win_max    = hi;
    dev_pct    = pct;
    conf_floor = thr;
    settings_used++;
  endtask

  // Nominal beat interval for the random traffic, inside the window when there is one.
  function automatic int pick_nominal();
    int hi;
    if (win_min > win_max) return $urandom_range(250, 2000);
    hi = (win_max > 3000 && win_min <= 3000) ? 3000 : win_max;
    return $urandom_range(win_min, hi);
  endfunction

  // Mostly a plausible heart rhythm with jitter, mixed with dropouts, extra
  // peaks, clock steps backwards, wild jumps and runs of repeated timestamps.
  task automatic run_traffic(input int count, input bit idle_allowed);
    int                 done_items;
    int                 base;
    int                 spread;
    int                 kind;
    int                 burst;
    logic [LEVEL_W-1:0] lvl;
    done_items = 0;
    gaps_on    = idle_allowed;
    stalls_on  = idle_allowed;
    base       = pick_nominal();
    while (done_items < count) begin
      if (idle_allowed && $urandom_range(0, 79) == 0) begin
        gaps_on   = ($urandom_range(0, 2) != 0);
        stalls_on = ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 19) == 0) base = pick_nominal();
      if (idle_allowed && $urandom_range(0, 99) == 0) wait_idle();

      burst = 1;
      kind  = $urandom_range(0, 99);
      if (kind < 70) begin
        spread = base * $urandom_range(0, 60) / 100;
        now_ms = ($urandom_range(0, 1) != 0) ? now_ms + base + spread
                                             : now_ms + base - spread;
      end else if (kind < 80) begin
        now_ms = now_ms + $urandom_range(0, base / 3);
      end else if (kind < 87) begin
        now_ms = now_ms + $urandom_range(base * 2, 80000);
      end else if (kind < 91) begin
        now_ms = now_ms - $urandom_range(0, 3000);
      end else if (kind < 95) begin
        now_ms = $urandom;
      end else begin
        burst = $urandom_range(3, 8);
      end

      repeat (burst) begin
        lvl       = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000);
        sample_no = ($urandom_range(0, 6) == 0) ? $urandom
                                                : sample_no + $urandom_range(20, 800);
        send_peak(now_ms, lvl, sample_no);
        done_items++;
      end
    end
  endtask

  // First peak gives nothing; the second has an empty history.
  task automatic test_first_peak();
    now_ms    = 200;
    sample_no = '0;
    send_after(800, 32'd0);
    sample_no = 32'hFFFF_FFFF;
    send_after(800, 32'h7FFF_FFFF);
  endtask

  // Window edges, median deviation alone and together with a window failure,
  // and the level clamp at both ends.
  task automatic test_window_and_median();
    send_after(800, 32'hFFFF_FFFF);
    send_after(800, 32'd65535);
    send_after(1000, 32'd65536);
    send_after(1100, 32'h8000_0000);
    send_after(299, 32'd1234);
    send_after(2001, 32'd1234);
    send_after(300, 32'd1234);
    send_after(2000, 32'd1234);
  endtask

  // Time running backwards, the saturation point and the top of the time range.
  task automatic test_time_edges();
    send_after(-5, 32'd800);
    send_after(65535, 32'd800);
    send_after(70000, 32'd800);
    now_ms = 32'hFFFF_FFFF;
    send_after(0, 32'd800);
    now_ms = 32'd0;
    send_after(0, 32'd800);
  endtask

  // Repeated timestamps fill the history with zeros until the median is zero.
  task automatic test_zero_median();
    repeat (4) send_after(0, 32'd500);
    send_after(800, 32'd500);
  endtask

  // Minimum above maximum, and a threshold above full confidence.
  task automatic test_bad_limits();
    apply_config(16'd2500, 16'd400, 8'd30, 8'd101);
    send_after(800, 32'd900);
    send_after(3000, 32'd900);
    send_after(800, 32'd900);
  endtask

  // Random traffic over a series of register settings, extremes included.
  task automatic test_random_traffic();
    apply_config(IVL_MIN_RST, IVL_MAX_RST, CHG_PCT_RST, CONF_THR_RST);
    run_traffic(PHASE_ITEMS, 1'b1);
    apply_config(16'd1, 16'd65535, 8'd1, 8'd0);
    run_traffic(PHASE_ITEMS, 1'b1);
    apply_config(16'd400, 16'd1500, 8'd255, 8'd255);
    run_traffic(PHASE_ITEMS, 1'b1);
    apply_config(16'd65535, 16'd1, 8'd50, 8'd101);
    run_traffic(PHASE_ITEMS, 1'b1);
    repeat (2) begin
      apply_config(16'($urandom_range(1, 1000)), 16'($urandom_range(800, 3000)),
                   8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
      run_traffic(PHASE_ITEMS, 1'b1);
    end
    apply_config(16'd250, 16'd2200, 8'd20, 8'd100);
    run_traffic(PHASE_ITEMS, 1'b1);
  endtask

  // Full-rate stream with no gaps and no back-pressure to close the run.
  task automatic test_steady_stream();
    apply_config(16'd350, 16'd1800, 8'd25, 8'd60);
    run_traffic(PHASE_ITEMS, 1'b0);
  endtask

  // Receiver: ready dropped in random bursts while stalls are enabled.
  initial begin
    beat_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!stalls_on) begin
        stall_left = 0;
        beat_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        beat_if.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 15);
        beat_if.ready <= 1'b0;
      end else begin
        beat_if.ready <= 1'b1;
      end
    end
  end

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  // Every beat word taken is matched against the oldest prediction.
  always @(posedge clk) begin : check_beat
    beat_t want;
    if (rst_n && beat_if.valid && beat_if.ready) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat word, expected none, got time %0d interval %0d",
                 $time, beat_if.beat_time_ms, beat_if.interval_ms);
        error_count++;
      end else begin
        want = pending_beats.pop_front();
        compare_field("beat_time_ms", want.beat_time, beat_if.beat_time_ms);
        compare_field("interval_ms", want.ivl, beat_if.interval_ms);
        compare_field("previous_interval_ms", want.prev_ivl, beat_if.previous_interval_ms);
        compare_field("confidence_pct", want.conf, beat_if.confidence_pct);
        compare_field("artifact_flag", want.art, beat_if.artifact_flag);
        compare_field("low_confidence_flag", want.low, beat_if.low_confidence_flag);
        compare_field("beat_level", want.level, beat_if.beat_level);
        compare_field("beat_sample", want.sample, beat_if.beat_sample);
        beats_checked++;
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles with %0d beat words outstanding.",
             cycle_count, pending_beats.size());
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_addr             <= CFG_IVL_MIN;
    cfg_wdata            <= '0;
    peak_if.valid        <= 1'b0;
    peak_if.peak_time_ms <= '0;
    peak_if.peak_level   <= '0;
    peak_if.peak_sample  <= '0;
    win_min    = IVL_MIN_RST;
    win_max    = IVL_MAX_RST;
    dev_pct    = CHG_PCT_RST;
    conf_floor = CONF_THR_RST;
    have_first = 1'b0;
    prev_time  = '0;
    prev_ivl   = '0;
    hist_pos   = 0;
    hist_fill  = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_peak();
    test_window_and_median();
    test_time_edges();
    test_zero_median();
    test_bad_limits();
    test_random_traffic();
    test_steady_stream();
    wait_idle();

    $display("Sent %0d peak words and checked %0d beat words over %0d register settings.",
             peaks_sent, beats_checked, settings_used);
    $display("Window, median, backward time, saturation and level clamp cases were hit.");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
